### hdl/binf_pkg.sv
// ----------------------------------------------------------------------------
// Package for the binary image neighbor fill
// Shared widths, register codes, the result record and the fill rule.
// ----------------------------------------------------------------------------
package binf_pkg;

    localparam int SIDE_W      = 8;
    localparam int THR_W       = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 8'd128;
    localparam logic [THR_W-1:0]  THR_RESET  = 3'd3;

    localparam logic REG_IMAGE_SIDE     = 1'b0;
    localparam logic REG_FILL_THRESHOLD = 1'b1;

    localparam int RES_PER_ITEM = 3;
    localparam int QDEPTH       = 8;
    localparam int QAW          = 3;
    localparam int QCW          = 4;

    typedef struct packed {
        logic last_of_run;
        logic frame_end;
        logic row_end;
        logic pixel_out;
    } t_result;

    function automatic logic fill_pixel(
        input logic             ctr,
        input logic             up,
        input logic             dn,
        input logic             lf,
        input logic             rt,
        input logic [THR_W-1:0] thr
    );
        logic [2:0] cnt;
        cnt = 3'(up) + 3'(dn) + 3'(lf) + 3'(rt);
        return ctr | (cnt >= thr);
    endfunction

endpackage

### hdl/binary_image_neighbor_fill.sv
// ----------------------------------------------------------------------------
// Binary image neighbor fill
// Streams a square binary image one pixel per word in row-major order and
// returns it with every zero pixel set to one when at least fill_threshold of
// its four neighbors are one. The output trails the input by one row: the
// first row yields no word, each later row yields one word per input, and in
// the last row every input after the first yields two words (the final input
// three). One input word is taken per clock while the eight-entry result queue
// has room for three results, so rows before the last run at one pixel per
// clock; the last row, at two words per pixel, is paced by the single output
// port. The two line buffers are one-bit memories with a registered read; each
// input writes its column, reads the next column of the older buffer and the one
// after it of the newer, with write forwarding; neither needs clearing after reset.
// ----------------------------------------------------------------------------
module binary_image_neighbor_fill #(
    parameter int MAX_SIDE = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // Bit 0 pixel_in, bits 7..1 zero.
    input  logic [binf_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // Bit 0 pixel_out, bit 1 row_end, bit 2 frame_end, bits 7..3 zero.
    output logic [binf_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                              o_m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [binf_pkg::APB_AW-1:0]       paddr,
    input  logic [binf_pkg::APB_DW-1:0]       pwdata,
    output logic [binf_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int EW = (AW + 1 > binf_pkg::SIDE_W) ? AW + 1 : binf_pkg::SIDE_W;
    localparam logic [EW-1:0] SIDE_MAX = EW'(MAX_SIDE);

    logic [binf_pkg::SIDE_W-1:0] r_side;
    logic [binf_pkg::THR_W-1:0]  r_thr;

    logic [AW-1:0] r_col;
    logic [AW-1:0] r_row;
    logic          r_prev;
    logic          r_p1;
    logic          r_p2;
    logic          r_first;
    logic          r_ctr;

    logic          mem_older [MAX_SIDE];
    logic          mem_newer [MAX_SIDE];
    logic          r_older_q;
    logic          r_newer_q;

    binf_pkg::t_result        r_q [binf_pkg::QDEPTH];
    logic [binf_pkg::QAW-1:0] r_wp;
    logic [binf_pkg::QAW-1:0] r_rp;
    logic [binf_pkg::QCW-1:0] r_qcnt;
    logic [binf_pkg::QCW-1:0] n_qcnt;

    logic          cfg_wr;
    logic [EW-1:0] side_ext;
    logic [EW-1:0] eff_side;
    logic [AW:0]   col_inc;
    logic [AW:0]   row_inc;
    logic          last_col;
    logic          last_row;
    logic          accept;
    logic          pop;
    logic          pin;
    logic [AW-1:0] n_col;
    logic [AW-1:0] n_row;
    logic [AW-1:0] rd_older_addr;
    logic [AW-1:0] rd_newer_addr;
    logic          n_ctr;
    logic          row_ge1;
    logic          row_ge2;
    logic          col_ge1;
    logic          col_ge2;

    binf_pkg::t_result cand  [binf_pkg::RES_PER_ITEM];
    logic              cand_v[binf_pkg::RES_PER_ITEM];
    binf_pkg::t_result slot  [binf_pkg::RES_PER_ITEM];
    logic [1:0]        n_push;
    binf_pkg::t_result head;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        if (paddr[2] == binf_pkg::REG_FILL_THRESHOLD) begin
            prdata = binf_pkg::APB_DW'(r_thr);
        end else begin
            prdata = binf_pkg::APB_DW'(r_side);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= binf_pkg::SIDE_RESET;
            r_thr  <= binf_pkg::THR_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == binf_pkg::REG_IMAGE_SIDE) begin
                r_side <= pwdata[binf_pkg::SIDE_W-1:0];
            end else begin
                r_thr <= pwdata[binf_pkg::THR_W-1:0];
            end
        end
    end

    // Position and handshake.
    assign side_ext = EW'(r_side);
    assign eff_side = (side_ext == '0) ? EW'(1) :
                      (side_ext > SIDE_MAX) ? SIDE_MAX : side_ext;
    assign col_inc  = {1'b0, r_col} + (AW+1)'(1);
    assign row_inc  = {1'b0, r_row} + (AW+1)'(1);
    assign last_col = EW'(col_inc) >= eff_side;
    assign last_row = EW'(row_inc) >= eff_side;

    assign o_s_axis_tready = r_qcnt <= binf_pkg::QCW'(binf_pkg::QDEPTH - binf_pkg::RES_PER_ITEM);
    assign accept = i_s_axis_tvalid & o_s_axis_tready;
    assign pin    = i_s_axis_tdata[0];

    assign n_col = last_col ? '0 : col_inc[AW-1:0];
    assign n_row = last_col ? (last_row ? '0 : row_inc[AW-1:0]) : r_row;
    assign rd_older_addr = n_col;
    assign rd_newer_addr = n_col + AW'(1);
    assign n_ctr = last_col ? ((r_col == '0) ? pin : r_first) : r_newer_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_prev <= 1'b0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_prev <= r_ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1  <= pin;
            r_p2  <= r_p1;
            r_ctr <= n_ctr;
            if (r_col == '0) begin
                r_first <= pin;
            end
        end
    end

    // Line buffers with write-first forwarding on the read port.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem_older[r_col] <= r_ctr;
            mem_newer[r_col] <= pin;
            r_older_q <= (rd_older_addr == r_col) ? r_ctr : mem_older[rd_older_addr];
            r_newer_q <= (rd_newer_addr == r_col) ? pin : mem_newer[rd_newer_addr];
        end
    end

    // Results caused by one input.
    assign row_ge1 = r_row != '0;
    assign row_ge2 = r_row > AW'(1);
    assign col_ge1 = r_col != '0;
    assign col_ge2 = r_col > AW'(1);

    always_comb begin
        cand[0].pixel_out   = binf_pkg::fill_pixel(r_ctr, row_ge2 & r_older_q, pin,
                                  col_ge1 & r_prev, ~last_col & r_newer_q, r_thr);
        cand[0].row_end     = last_col;
        cand[0].frame_end   = 1'b0;
        cand[0].last_of_run = 1'b0;
        cand_v[0]           = row_ge1;

        cand[1].pixel_out   = binf_pkg::fill_pixel(r_p1, row_ge1 & r_prev, 1'b0,
                                  col_ge2 & r_p2, pin, r_thr);
        cand[1].row_end     = 1'b0;
        cand[1].frame_end   = 1'b0;
        cand[1].last_of_run = 1'b0;
        cand_v[1]           = last_row & col_ge1;

        cand[2].pixel_out   = binf_pkg::fill_pixel(pin, row_ge1 & r_ctr, 1'b0,
                                  col_ge1 & r_p1, 1'b0, r_thr);
        cand[2].row_end     = 1'b1;
        cand[2].frame_end   = 1'b1;
        cand[2].last_of_run = 1'b0;
        cand_v[2]           = last_row & last_col;
    end

    always_comb begin
        n_push = 2'd0;
        for (int i = 0; i < binf_pkg::RES_PER_ITEM; i++) begin
            slot[i] = '0;
        end
        for (int i = 0; i < binf_pkg::RES_PER_ITEM; i++) begin
            if (cand_v[i]) begin
                slot[n_push] = cand[i];
                n_push       = n_push + 2'd1;
            end
        end
        for (int i = 0; i < binf_pkg::RES_PER_ITEM; i++) begin
            slot[i].last_of_run = (2'(i) + 2'd1 == n_push);
        end
    end

    // Result queue.
    assign head = r_q[r_rp];
    assign pop  = o_m_axis_tvalid & i_m_axis_tready;
    assign o_m_axis_tvalid = r_qcnt != '0;
    assign o_m_axis_tdata  = {(binf_pkg::OUT_TDATA_W-3)'(0),
                              head.frame_end, head.row_end, head.pixel_out};
    assign o_m_axis_tlast  = head.last_of_run;

    always_comb begin
        n_qcnt = r_qcnt;
        if (accept) begin
            n_qcnt = n_qcnt + binf_pkg::QCW'(n_push);
        end
        if (pop) begin
            n_qcnt = n_qcnt - binf_pkg::QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            r_qcnt <= n_qcnt;
            if (accept) begin
                r_wp <= r_wp + binf_pkg::QAW'(n_push);
            end
            if (pop) begin
                r_rp <= r_rp + binf_pkg::QAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < binf_pkg::RES_PER_ITEM; i++) begin
            if (accept && (2'(i) < n_push)) begin
                r_q[r_wp + binf_pkg::QAW'(i)] <= slot[i];
            end
        end
    end

    // Checks.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= binf_pkg::QCW'(binf_pkg::QDEPTH))
        else $error("result queue holds more entries than its depth");

    a_row_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_row != '0)) |=> (r_qcnt != '0))
        else $error("pixel after the first row produced no result");

    a_frame_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && head.frame_end) |-> (head.row_end && head.last_of_run))
        else $error("frame end without row end or end of run");

endmodule

### tb/sv/tb_binary_image_neighbor_fill.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the binary image neighbor fill
// Streams square binary frames of many sides and thresholds through the
// block, predicts every filtered word in a scoreboard class and checks each
// output word, with random idling on both stream sides and one long output
// hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_binary_image_neighbor_fill;

    localparam int MAX_SIDE      = 128;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 64;

    localparam logic [binf_pkg::APB_AW-1:0] ADDR_SIDE = {binf_pkg::REG_IMAGE_SIDE, 2'b00};
    localparam logic [binf_pkg::APB_AW-1:0] ADDR_THR  = {binf_pkg::REG_FILL_THRESHOLD, 2'b00};

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    class t_fill_scoreboard;
        bit                          older_row[MAX_SIDE];
        bit                          newer_row[MAX_SIDE];
        int unsigned                 row_pos;
        int unsigned                 col_pos;
        bit                          left_pixel;
        logic [binf_pkg::SIDE_W-1:0] side_reg;
        logic [binf_pkg::THR_W-1:0]  thr_reg;
        binf_pkg::t_result           expected_words[$];
        int unsigned                 fails;

        function new();
            row_pos    = 0;
            col_pos    = 0;
            left_pixel = 1'b0;
            side_reg   = binf_pkg::SIDE_RESET;
            thr_reg    = binf_pkg::THR_RESET;
            fails      = 0;
            foreach (older_row[i]) older_row[i] = 1'b0;
            foreach (newer_row[i]) newer_row[i] = 1'b0;
        endfunction

        function void set_side(logic [binf_pkg::SIDE_W-1:0] v);
            side_reg = v;
        endfunction

        function void set_threshold(logic [binf_pkg::THR_W-1:0] v);
            thr_reg = v;
        endfunction

        function int unsigned active_side();
            if (side_reg == 0) return 1;
            if (side_reg > MAX_SIDE) return MAX_SIDE;
            return side_reg;
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        function bit filled(bit ctr, bit up, bit dn, bit lf, bit rt);
            int unsigned ones;
            ones = up + dn + lf + rt;
            return ctr || (ones >= thr_reg);
        endfunction

        function void note_pixel(bit p);
            int unsigned       side;
            int unsigned       r;
            int unsigned       c;
            bit                at_last_col;
            bit                at_last_row;
            bit                above_old;
            bit                center_old;
            binf_pkg::t_result words[3];
            int                n;
            side        = active_side();
            r           = row_pos;
            c           = col_pos;
            at_last_col = (c + 1 >= side);
            at_last_row = (r + 1 >= side);
            above_old   = older_row[c];
            center_old  = newer_row[c];
            n           = 0;
            words[0]    = '0;
            words[1]    = '0;
            words[2]    = '0;

            // The previous row is emitted one pixel per input.
            if (r >= 1) begin
                words[n].pixel_out = filled(center_old, (r >= 2) ? above_old : 1'b0, p,
                                            (c > 0) ? left_pixel : 1'b0,
                                            at_last_col ? 1'b0 : newer_row[c + 1]);
                words[n].row_end = at_last_col;
                n++;
            end

            older_row[c] = center_old;
            newer_row[c] = p;
            left_pixel   = center_old;

            // In the last row the pixel one column behind follows, and the
            // last input also closes the image.
            if (at_last_row) begin
                if (c >= 1) begin
                    words[n].pixel_out = filled(newer_row[c - 1],
                                                (r >= 1) ? older_row[c - 1] : 1'b0, 1'b0,
                                                (c >= 2) ? newer_row[c - 2] : 1'b0, p);
                    n++;
                end
                if (at_last_col) begin
                    words[n].pixel_out = filled(p, (r >= 1) ? center_old : 1'b0, 1'b0,
                                                (c >= 1) ? newer_row[c - 1] : 1'b0, 1'b0);
                    words[n].row_end   = 1'b1;
                    words[n].frame_end = 1'b1;
                    n++;
                end
            end

            if (at_last_col) begin
                col_pos = 0;
                row_pos = at_last_row ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
            end

            for (int k = 0; k < n; k++) begin
                words[k].last_of_run = (k == n - 1);
                expected_words.push_back(words[k]);
            end
        endfunction

        function void check_word(logic [binf_pkg::OUT_TDATA_W-1:0] data, logic last);
            binf_pkg::t_result w;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got tdata=%h tlast=%b",
                         $time, data, last);
                fails++;
                return;
            end
            w = expected_words.pop_front();
            if (data[0] !== w.pixel_out || data[1] !== w.row_end
                    || data[2] !== w.frame_end || last !== w.last_of_run
                    || data[binf_pkg::OUT_TDATA_W-1:3] !== '0) begin
                $display("%0t: mismatch, exp pix=%b re=%b fe=%b last=%b, got tdata=%h tlast=%b",
                         $time, w.pixel_out, w.row_end, w.frame_end, w.last_of_run,
                         data, last);
                fails++;
            end
        endfunction
    endclass

    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    logic [binf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata  = '0;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    logic [binf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata;
    logic                                o_m_axis_tlast;
    logic                                psel            = 1'b0;
    logic                                penable         = 1'b0;
    logic                                pwrite          = 1'b0;
    logic [binf_pkg::APB_AW-1:0]         paddr           = '0;
    logic [binf_pkg::APB_DW-1:0]         pwdata          = '0;
    logic [binf_pkg::APB_DW-1:0]         prdata;
    logic                                pready;

    t_fill_scoreboard sb          = new();
    t_idle_mode       idle_mode   = IDLE_NONE;
    bit               hold_req    = 1'b0;
    int               hold_left   = 0;
    int unsigned      cycle_count = 0;

    binary_image_neighbor_fill #(
        .MAX_SIDE(MAX_SIDE)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever @(posedge i_clk) begin
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES) begin
                $display("FAIL binary_image_neighbor_fill");
                $finish;
            end
        end
    end

    // Output side: checks each accepted word and drives tready, with a long
    // hold-off on request.
    initial begin
        forever @(posedge i_clk) begin
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_word(o_m_axis_tdata, o_m_axis_tlast);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                case (idle_mode)
                    IDLE_RECV: i_m_axis_tready <= ($urandom_range(0, 99) >= 85);
                    IDLE_BOTH: i_m_axis_tready <= ($urandom_range(0, 99) >= 6);
                    default:   i_m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 85;
            IDLE_BOTH: return $urandom_range(0, 99) < 6;
            default:   return 1'b0;
        endcase
    endfunction

    task automatic send_word(input bit p);
        while (sender_idles()) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= binf_pkg::IN_TDATA_W'(p);
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_pixel(p);
    endtask

    task automatic send_bits(input int n, input logic [31:0] bits);
        for (int i = 0; i < n; i++) send_word(bits[i]);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_frame(input int density);
        int unsigned n;
        n = sb.active_side() * sb.active_side();
        for (int unsigned i = 0; i < n; i++) send_word($urandom_range(0, 99) < density);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_block();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [binf_pkg::APB_AW-1:0] addr,
                             input logic [binf_pkg::APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [binf_pkg::SIDE_W-1:0] side,
                              input logic [binf_pkg::THR_W-1:0] thr);
        drain_block();
        apb_write(ADDR_SIDE, binf_pkg::APB_DW'(side));
        sb.set_side(side);
        apb_write(ADDR_THR, binf_pkg::APB_DW'(thr));
        sb.set_threshold(thr);
    endtask

    initial begin
        int unsigned                 items;
        logic [binf_pkg::SIDE_W-1:0] side_v;
        logic [binf_pkg::THR_W-1:0]  thr_v;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A small frame at the reset threshold.
        apb_write(ADDR_SIDE, 32'd4);
        sb.set_side(8'd4);
        send_frame(50);

        // A surrounded zero fills at a threshold of four; zero always fills,
        // seven never does; sides of one and zero give one word per frame.
        set_config(8'd3, 3'd4);
        send_bits(9, 32'h0AA);
        set_config(8'd3, 3'd0);
        send_bits(9, 32'h000);
        set_config(8'd2, 3'd7);
        send_bits(4, 32'h009);
        set_config(8'd1, 3'd3);
        send_bits(2, 32'h1);
        set_config(8'd0, 3'd1);
        send_bits(1, 32'h1);

        for (int ph = 0; ph < 4; ph++) begin
            drain_block();
            idle_mode = t_idle_mode'(ph);
            items = 0;
            while (items < PHASE_ITEMS) begin
                side_v = ($urandom_range(0, 9) == 0)
                       ? binf_pkg::SIDE_W'($urandom_range(0, 12))
                       : binf_pkg::SIDE_W'($urandom_range(1, 7));
                thr_v  = ($urandom_range(0, 3) == 0)
                       ? binf_pkg::THR_W'($urandom_range(0, 7))
                       : binf_pkg::THR_W'($urandom_range(1, 4));
                if (ph == 0 && items == 0) side_v = 8'd6;
                set_config(side_v, thr_v);
                if (ph == 0 && items == 0) hold_req = 1'b1;
                send_frame($urandom_range(0, 100));
                items += sb.active_side() * sb.active_side();
            end
        end

        // A side above the maximum is clamped to it: one full row and a few
        // pixels of the next show the row wrapping at the maximum.
        drain_block();
        idle_mode = IDLE_NONE;
        set_config(8'd255, 3'd1);
        for (int i = 0; i < MAX_SIDE + 4; i++) send_word($urandom_range(0, 99) < 30);
        i_s_axis_tvalid <= 1'b0;

        drain_block();
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("PASS binary_image_neighbor_fill");
        end else begin
            $display("FAIL binary_image_neighbor_fill");
        end
        $finish;
    end

endmodule

### binary_image_neighbor_fill.f
hdl/binf_pkg.sv
hdl/binary_image_neighbor_fill.sv
tb/sv/tb_binary_image_neighbor_fill.sv
